@@ sv/owbm_pkg.sv @@
// Shared types and constants for the one-wire bus master core.
package owbm_pkg;

	localparam int unsigned REG_W     = 10;
	localparam int unsigned NUM_REGS  = 8;
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned IN_DATA_W  = 16;
	localparam int unsigned IN_USER_W  = 2;
	localparam int unsigned OUT_DATA_W = 16;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_RESET = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_RESET_LOW   = 3'd0,
		REG_PRES_WAIT   = 3'd1,
		REG_RST_RECOVER = 3'd2,
		REG_WR_LEAD     = 3'd3,
		REG_WR_HOLD     = 3'd4,
		REG_RD_LOW      = 3'd5,
		REG_RD_SAMPLE   = 3'd6,
		REG_RD_RECOVER  = 3'd7
	} reg_idx_t;

	localparam logic [REG_W-1:0] CFG_RESET [NUM_REGS] = '{
		10'd480, 10'd65, 10'd480, 10'd10, 10'd50, 10'd5, 10'd10, 10'd45
	};

	typedef enum logic [9:0] {
		PH_IDLE        = 10'b00_0000_0001,
		PH_RST_LOW     = 10'b00_0000_0010,
		PH_RST_WAIT    = 10'b00_0000_0100,
		PH_RST_RECOVER = 10'b00_0000_1000,
		PH_WR_LEAD     = 10'b00_0001_0000,
		PH_WR_HOLD     = 10'b00_0010_0000,
		PH_WR_GAP      = 10'b00_0100_0000,
		PH_RD_LOW      = 10'b00_1000_0000,
		PH_RD_WAIT     = 10'b01_0000_0000,
		PH_RD_RECOVER  = 10'b10_0000_0000
	} phase_t;

endpackage

@@ sv/one_wire_bus_master_core.sv @@
// One-wire bus master sequencer core: reset, write-byte and read-byte sequences.
// The result word for an accepted input word is registered and appears in the cycle after acceptance.
// Throughput: one input word per cycle; the output register acts as the only stage,
// so a word is taken whenever that register is empty or is being drained.
// Each tick word advances the sequencer by one microsecond of bus time.
// Reset (arst_n low) restores the timing registers, idles the sequencer, empties the output.
module one_wire_bus_master_core #(
	parameter int unsigned COUNT_WIDTH = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [7:0] write_data, [8] line_level, [15:9] zero
	input  logic [owbm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// [1:0] op
	input  logic [owbm_pkg::IN_USER_W-1:0]     s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [0] drive_low, [1] busy_res, [2] done_res, [3] presence_bit,
	// [11:4] read_byte, [12] rejected, [15:13] zero
	output logic [owbm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [owbm_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [owbm_pkg::REG_W-1:0]         cfg_data
);

	localparam int unsigned LW =
		((COUNT_WIDTH > owbm_pkg::REG_W) ? COUNT_WIDTH : owbm_pkg::REG_W) + 1;

	logic [owbm_pkg::REG_W-1:0] cfg_q [owbm_pkg::NUM_REGS];

	owbm_pkg::phase_t       phase_q, phase_d;
	logic [COUNT_WIDTH-1:0] tick_q, tick_d;
	logic [2:0]             bit_q, bit_d;
	logic [7:0]             shift_q, shift_d;
	logic                   pres_q, pres_d;
	logic [7:0]             rd_res_q, rd_res_d;

	logic                   out_valid_q;
	logic [owbm_pkg::OUT_DATA_W-1:0] out_data_q;

	logic                   accept;
	owbm_pkg::op_t          op;
	logic [7:0]             wr_data;
	logic                   level;
	logic [owbm_pkg::REG_W-1:0] len_raw;
	logic [LW-1:0]          len_ext, len, cnt_next;
	logic                   done, rej, drive;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign op            = owbm_pkg::op_t'(s_axis_tuser);
	assign wr_data       = s_axis_tdata[7:0];
	assign level         = s_axis_tdata[8];
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= owbm_pkg::CFG_RESET;
		end else if (cfg_valid) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// Length of the current phase, taken from its timing register.
	always_comb begin
		unique case (phase_q)
			owbm_pkg::PH_RST_LOW:     len_raw = cfg_q[owbm_pkg::REG_RESET_LOW];
			owbm_pkg::PH_RST_WAIT:    len_raw = cfg_q[owbm_pkg::REG_PRES_WAIT];
			owbm_pkg::PH_RST_RECOVER: len_raw = cfg_q[owbm_pkg::REG_RST_RECOVER];
			owbm_pkg::PH_WR_LEAD:     len_raw = cfg_q[owbm_pkg::REG_WR_LEAD];
			owbm_pkg::PH_WR_HOLD:     len_raw = cfg_q[owbm_pkg::REG_WR_HOLD];
			owbm_pkg::PH_RD_LOW:      len_raw = cfg_q[owbm_pkg::REG_RD_LOW];
			owbm_pkg::PH_RD_WAIT:     len_raw = cfg_q[owbm_pkg::REG_RD_SAMPLE];
			owbm_pkg::PH_RD_RECOVER:  len_raw = cfg_q[owbm_pkg::REG_RD_RECOVER];
			default:                  len_raw = {{(owbm_pkg::REG_W-1){1'b0}}, 1'b1};
		endcase
	end

	// A zero length counts as one tick; lengths beyond the counter saturate.
	always_comb begin
		len_ext = {{(LW-owbm_pkg::REG_W){1'b0}}, len_raw};
		if (len_raw == '0) begin
			len = {{(LW-1){1'b0}}, 1'b1};
		end else if (len_ext > {{(LW-COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}}) begin
			len = {{(LW-COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};
		end else begin
			len = len_ext;
		end
		cnt_next = {{(LW-COUNT_WIDTH){1'b0}}, tick_q} + {{(LW-1){1'b0}}, 1'b1};
	end

	always_comb begin
		phase_d  = phase_q;
		tick_d   = tick_q;
		bit_d    = bit_q;
		shift_d  = shift_q;
		pres_d   = pres_q;
		rd_res_d = rd_res_q;
		done     = 1'b0;
		rej      = 1'b0;
		if (op == owbm_pkg::OP_TICK) begin
			if (phase_q != owbm_pkg::PH_IDLE) begin
				if (cnt_next < len) begin
					tick_d = cnt_next[COUNT_WIDTH-1:0];
				end else begin
					tick_d = '0;
					unique case (phase_q)
						owbm_pkg::PH_RST_LOW: phase_d = owbm_pkg::PH_RST_WAIT;
						owbm_pkg::PH_RST_WAIT: begin
							pres_d  = level;
							phase_d = owbm_pkg::PH_RST_RECOVER;
						end
						owbm_pkg::PH_RST_RECOVER: begin
							phase_d = owbm_pkg::PH_IDLE;
							done    = 1'b1;
						end
						owbm_pkg::PH_WR_LEAD: phase_d = owbm_pkg::PH_WR_HOLD;
						owbm_pkg::PH_WR_HOLD: begin
							if (bit_q == 3'd7) begin
								phase_d = owbm_pkg::PH_IDLE;
								done    = 1'b1;
							end else begin
								phase_d = owbm_pkg::PH_WR_GAP;
							end
						end
						owbm_pkg::PH_WR_GAP: begin
							bit_d   = bit_q + 3'd1;
							phase_d = owbm_pkg::PH_WR_LEAD;
						end
						owbm_pkg::PH_RD_LOW: phase_d = owbm_pkg::PH_RD_WAIT;
						owbm_pkg::PH_RD_WAIT: begin
							shift_d[bit_q] = shift_q[bit_q] | level;
							phase_d        = owbm_pkg::PH_RD_RECOVER;
						end
						owbm_pkg::PH_RD_RECOVER: begin
							if (bit_q == 3'd7) begin
								rd_res_d = shift_q;
								phase_d  = owbm_pkg::PH_IDLE;
								done     = 1'b1;
							end else begin
								bit_d   = bit_q + 3'd1;
								phase_d = owbm_pkg::PH_RD_LOW;
							end
						end
						default: phase_d = owbm_pkg::PH_IDLE;
					endcase
				end
			end
		end else if (phase_q != owbm_pkg::PH_IDLE) begin
			rej = 1'b1;
		end else begin
			bit_d  = 3'd0;
			tick_d = '0;
			unique case (op)
				owbm_pkg::OP_RESET: phase_d = owbm_pkg::PH_RST_LOW;
				owbm_pkg::OP_WRITE: begin
					shift_d = wr_data;
					phase_d = owbm_pkg::PH_WR_LEAD;
				end
				default: begin
					shift_d = 8'd0;
					phase_d = owbm_pkg::PH_RD_LOW;
				end
			endcase
		end
	end

	// Line drive follows the phase that the item moves the sequencer into.
	always_comb begin
		unique case (phase_d)
			owbm_pkg::PH_RST_LOW,
			owbm_pkg::PH_WR_LEAD,
			owbm_pkg::PH_RD_LOW:  drive = 1'b1;
			owbm_pkg::PH_WR_HOLD: drive = !shift_d[bit_d];
			default:              drive = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= owbm_pkg::PH_IDLE;
			tick_q   <= '0;
			bit_q    <= 3'd0;
			shift_q  <= 8'd0;
			pres_q   <= 1'b1;
			rd_res_q <= 8'd0;
		end else if (accept) begin
			phase_q  <= phase_d;
			tick_q   <= tick_d;
			bit_q    <= bit_d;
			shift_q  <= shift_d;
			pres_q   <= pres_d;
			rd_res_q <= rd_res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {3'b000, rej, rd_res_d, pres_d, done,
				(phase_d != owbm_pkg::PH_IDLE), drive};
		end
	end

endmodule

@@ sv/owbm_checker.sv @@
// Port-level checks for the one-wire bus master core, bound to the core module.
module owbm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [owbm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	// A stalled result word holds still until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result word changed");

	// With the output register empty the core must take a word.
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while output register empty");

	// A completing word reports the sequencer as idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[1] && !m_axis_tdata[12])
		else $error("done reported while busy or rejected");

	// The line is pulled low only during a sequence.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
		else $error("line driven low while idle");

	// A rejected command can only arrive while a sequence is in progress.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[12] |-> m_axis_tdata[1])
		else $error("command rejected while idle");

endmodule

bind one_wire_bus_master_core owbm_checker u_owbm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
